### sv/ebsd_pkg.sv
// Shared constants and types of the eye blink sequence detector.
package ebsd_pkg;

  localparam int EYE_PIXELS  = 512;
  localparam int PHASE_COUNT = 5;
  localparam int IDX_W       = $clog2(EYE_PIXELS);
  localparam int PHASE_W     = $clog2(PHASE_COUNT);
  localparam int SUM_W       = 48;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int SM_W        = 32;

  localparam logic [2:0] REG_IMAGE_RATE  = 3'd0;
  localparam logic [2:0] REG_SMOOTH_RATE = 3'd1;
  localparam logic [2:0] REG_RISE_THR    = 3'd2;
  localparam logic [2:0] REG_FALL_THR    = 3'd3;
  localparam logic [2:0] REG_RISE_MIN    = 3'd4;
  localparam logic [2:0] REG_RISE_MAX    = 3'd5;
  localparam logic [2:0] REG_FALL_MIN    = 3'd6;
  localparam logic [2:0] REG_FALL_MAX    = 3'd7;

  localparam logic [SM_W-1:0] SM_RESET = 32'd256000;

  typedef struct packed {
    logic [3:0] rise_min;
    logic [3:0] rise_max;
    logic [3:0] fall_min;
    logic [3:0] fall_max;
  } ebsd_dur_cfg_t;

  typedef struct packed {
    logic upd;
    logic rise_met;
    logic fall_met;
  } ebsd_ph_ctl_t;

endpackage

### sv/ebsd_if.sv
// Handshake interfaces for the pixel and result channels.
interface ebsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_pixel;
  modport source (output valid, pixel, last_pixel, input ready);
  modport sink (input valid, pixel, last_pixel, output ready);
endinterface

interface ebsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic [15:0] distance;
  modport source (output valid, phase, distance, input ready);
  modport sink (input valid, phase, distance, output ready);
endinterface

### sv/eye_blink_sequence_detector.sv
// Eye blink sequence detector: pixel datapath, average image memory and control.
// A pixel word runs through memory read, difference, multiply and write-back.
// A last pixel then adds the square root and the smoothing and phase logic.
// A new pixel word is taken only once the read-modify-write of the last one is done.
// Reset (synchronous, rst_n low) restores the register defaults and the frame state;
// the average image memory is not cleared, the first frame writes it.
module eye_blink_sequence_detector
  import ebsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ebsd_in_if.sink          in_word,
  ebsd_out_if.source       out_word,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  // Sequencer states. Pixel words run IDLE, DIFF, MUL, WB. A last pixel then
  // runs the square root, smoothing, threshold products, phase update and
  // finally hands the result to the output register.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIFF   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_WB     = 4'd3;
  localparam logic [3:0] ST_SQ_GO  = 4'd4;
  localparam logic [3:0] ST_SQRT   = 4'd5;
  localparam logic [3:0] ST_SM_LO  = 4'd6;
  localparam logic [3:0] ST_SM_HI  = 4'd7;
  localparam logic [3:0] ST_SM_ADD = 4'd8;
  localparam logic [3:0] ST_SM_FIN = 4'd9;
  localparam logic [3:0] ST_THR    = 4'd10;
  localparam logic [3:0] ST_PHASE  = 4'd11;
  localparam logic [3:0] ST_OUT    = 4'd12;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic [15:0]   image_rate_r, smooth_rate_r;
  logic [11:0]   rise_thr_r, fall_thr_r;
  ebsd_dur_cfg_t dur_cfg_r;

  // Frame state.
  logic             seeded_r;
  logic [IDX_W-1:0] idx_r;
  logic [SUM_W-1:0] sum_r;
  logic [SM_W-1:0]  sm_r;

  // Pixel pipeline registers.
  logic [7:0]         pix_r;
  logic               last_r;
  logic [15:0]        avg_r;
  logic signed [16:0] diff_r;
  logic [31:0]        sq_r;
  logic signed [33:0] rp_r;

  // The running-average image holds one Q8.8 entry per pixel position.
  logic [15:0] avg_mem [EYE_PIXELS];
  logic [15:0] rdata_r;
  logic        mem_we;
  logic [15:0] mem_wdata;

  // End-of-frame registers.
  logic [ROOT_W-1:0]  dist_r;
  logic [31:0]        plo_r;
  logic signed [34:0] phi_r;
  logic signed [50:0] prod_r;
  logic [43:0]        rise_prod_r, fall_prod_r;
  logic               out_valid_r;
  logic [2:0]         out_phase_r;
  logic [15:0]        out_dist_r;

  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W+2:0] phase_ext;
  ebsd_ph_ctl_t       ph_ctl;

  logic               accept;
  logic [15:0]        p8;
  logic [15:0]        absdiff;
  logic signed [33:0] rp_round;
  logic signed [33:0] sdiff;
  logic signed [35:0] sm_new;
  logic [SUM_W-1:0]   lhs;

  assign accept = in_word.valid && in_word.ready;
  assign in_word.ready = (state_r == ST_IDLE);
  assign p8 = {pix_r, 8'h00};
  assign absdiff = diff_r[16] ? 16'(-diff_r) : diff_r[15:0];
  // New average = avg + round(rate * (pixel - avg) / 2^16), with floor shift.
  assign rp_round = rp_r + 34'sd32768;
  assign mem_we = (state_r == ST_WB);
  assign mem_wdata = seeded_r ? avg_r + rp_round[31:16] : p8;
  assign sdiff = $signed({10'b0, dist_r}) - $signed({2'b0, sm_r});
  assign sm_new = $signed({4'b0, sm_r}) + 36'((prod_r + 51'sd32768) >>> 16);
  assign lhs = {{(SUM_W-ROOT_W-8){1'b0}}, dist_r, 8'h00};
  assign sq_start = (state_r == ST_SQ_GO);
  assign phase_ext = {3'b000, phase};

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= avg_mem[idx_r];
    end
    if (mem_we) begin
      avg_mem[idx_r] <= mem_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_WB;
      ST_WB:     state_nxt = last_r ? ST_SQ_GO : ST_IDLE;
      ST_SQ_GO:  state_nxt = ST_SQRT;
      ST_SQRT:   if (sq_done) state_nxt = ST_SM_LO;
      ST_SM_LO:  state_nxt = ST_SM_HI;
      ST_SM_HI:  state_nxt = ST_SM_ADD;
      ST_SM_ADD: state_nxt = ST_SM_FIN;
      ST_SM_FIN: state_nxt = ST_THR;
      ST_THR:    state_nxt = ST_PHASE;
      ST_PHASE:  state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_word.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ph_ctl.upd      = (state_r == ST_PHASE);
    ph_ctl.rise_met = lhs >= {{(SUM_W-44){1'b0}}, rise_prod_r};
    ph_ctl.fall_met = lhs <= {{(SUM_W-44){1'b0}}, fall_prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      image_rate_r      <= 16'd3277;
      smooth_rate_r     <= 16'd6554;
      rise_thr_r        <= 12'd461;
      fall_thr_r        <= 12'd358;
      dur_cfg_r         <= '{rise_min: 4'd1, rise_max: 4'd8, fall_min: 4'd3, fall_max: 4'd6};
      seeded_r          <= 1'b0;
      idx_r             <= '0;
      sum_r             <= '0;
      sm_r              <= SM_RESET;
      out_valid_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_RATE:  image_rate_r       <= cfg_data;
          REG_SMOOTH_RATE: smooth_rate_r      <= cfg_data;
          REG_RISE_THR:    rise_thr_r         <= cfg_data[11:0];
          REG_FALL_THR:    fall_thr_r         <= cfg_data[11:0];
          REG_RISE_MIN:    dur_cfg_r.rise_min <= cfg_data[3:0];
          REG_RISE_MAX:    dur_cfg_r.rise_max <= cfg_data[3:0];
          REG_FALL_MIN:    dur_cfg_r.fall_min <= cfg_data[3:0];
          REG_FALL_MAX:    dur_cfg_r.fall_max <= cfg_data[3:0];
          default:         ;
        endcase
      end
      if (state_r == ST_WB) begin
        if (seeded_r) begin
          sum_r <= sum_r + {{(SUM_W-32){1'b0}}, sq_r};
        end
        // A frame that runs past the image size wraps to the first position.
        if (!last_r) begin
          idx_r <= (idx_r == IDX_W'(EYE_PIXELS-1)) ? '0 : idx_r + 1'b1;
        end
      end
      if (state_r == ST_SM_FIN) begin
        // The smoothed distance is held at one LSB or more.
        if (sm_new < 36'sd1) begin
          sm_r <= 32'd1;
        end else if (sm_new > 36'sh0_FFFF_FFFF) begin
          sm_r <= 32'hFFFF_FFFF;
        end else begin
          sm_r <= sm_new[31:0];
        end
      end
      // A new result word may replace one that leaves in the same cycle.
      if ((state_r == ST_OUT) && (!out_valid_r || out_word.ready)) begin
        out_valid_r <= 1'b1;
        seeded_r    <= 1'b1;
        idx_r       <= '0;
        sum_r       <= '0;
      end else if (out_valid_r && out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= in_word.pixel;
      last_r <= in_word.last_pixel;
    end
    if (state_r == ST_DIFF) begin
      avg_r  <= rdata_r;
      diff_r <= $signed({1'b0, p8}) - $signed({1'b0, rdata_r});
    end
    if (state_r == ST_MUL) begin
      sq_r <= absdiff * absdiff;
      rp_r <= $signed({1'b0, image_rate_r}) * diff_r;
    end
    if ((state_r == ST_SQRT) && sq_done) begin
      dist_r <= sq_root;
    end
    if (state_r == ST_SM_LO) begin
      plo_r <= smooth_rate_r * sdiff[15:0];
    end
    if (state_r == ST_SM_HI) begin
      phi_r <= $signed({1'b0, smooth_rate_r}) * $signed(sdiff[33:16]);
    end
    if (state_r == ST_SM_ADD) begin
      prod_r <= ($signed({{16{phi_r[34]}}, phi_r}) <<< 16) + $signed({19'b0, plo_r});
    end
    if (state_r == ST_THR) begin
      rise_prod_r <= rise_thr_r * sm_r;
      fall_prod_r <= fall_thr_r * sm_r;
    end
    if ((state_r == ST_OUT) && (!out_valid_r || out_word.ready)) begin
      out_phase_r <= phase_ext[2:0];
      out_dist_r  <= dist_r[ROOT_W-1:8];
    end
  end

  ebsd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  ebsd_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ph_ctl),
    .dur_cfg (dur_cfg_r),
    .phase   (phase)
  );

  assign out_word.valid    = out_valid_r;
  assign out_word.phase    = out_phase_r;
  assign out_word.distance = out_dist_r;

endmodule

### sv/ebsd_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module ebsd_isqrt
  import ebsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W-1:0] v_r, v_nxt;
  logic [SUM_W-1:0] res_r, res_nxt;
  logic [SUM_W-1:0] bit_r, bit_nxt;
  logic [SUM_W-1:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = radicand;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(SUM_W-2){1'b0}}};
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == {{(SUM_W-1){1'b0}}, 1'b1}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

### sv/ebsd_phase.sv
// Open/close phase machine with minimum and maximum durations.
module ebsd_phase
  import ebsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ebsd_ph_ctl_t       ctl,
  input  ebsd_dur_cfg_t      dur_cfg,
  output logic [PHASE_W-1:0] phase
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [3:0]         frames_r, frames_nxt;
  logic [4:0]         dur;
  logic [PHASE_W-1:0] ph;
  logic [PHASE_W:0]   ph_inc;
  logic [3:0]         mn, mx;
  logic               met_cur, met_next;

  always_comb begin
    dur     = {1'b0, frames_r} + 5'd1;
    ph      = phase_r;
    mn      = phase_r[0] ? dur_cfg.rise_min : dur_cfg.fall_min;
    mx      = phase_r[0] ? dur_cfg.rise_max : dur_cfg.fall_max;
    met_cur = phase_r[0] ? ctl.rise_met : ctl.fall_met;
    if (phase_r != '0) begin
      if (((dur < {1'b0, mn}) && !met_cur) || (dur > {1'b0, mx})) begin
        ph  = '0;
        dur = '0;
      end
    end
    ph_inc   = {1'b0, ph} + {{PHASE_W{1'b0}}, 1'b1};
    // The next phase rises when it is odd and falls when it is even.
    met_next = ph_inc[0] ? ctl.rise_met : ctl.fall_met;
    if ((ph_inc < (PHASE_W+1)'(PHASE_COUNT)) && met_next) begin
      ph  = ph_inc[PHASE_W-1:0];
      dur = '0;
    end
    phase_nxt  = ctl.upd ? ph : phase_r;
    frames_nxt = frames_r;
    if (ctl.upd) begin
      frames_nxt = dur[4] ? 4'd15 : dur[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      frames_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      frames_r <= frames_nxt;
    end
  end

  assign phase = phase_r;

endmodule

### sv/ebsd_checker.sv
// Port-level checks of the detector and their binding to the top level.
module ebsd_sva
  import ebsd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_phase
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase < 3'(PHASE_COUNT)))
    else $error("phase out of range");

  a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result right after a pixel word");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel word taken while one is in work");

endmodule

bind eye_blink_sequence_detector ebsd_sva u_ebsd_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .out_phase (out_word.phase)
);

### bench/ebsd_checker.sv
// Checker for the eye blink sequence detector: watches the channels, predicts and compares.
`timescale 1ns / 100ps
module ebsd_checker
  import ebsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_pixel,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_phase,
  input  logic [15:0] out_distance,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] distance;
  } blink_word_t;

  blink_word_t       blink_q[$];
  logic [15:0]       avg_img [EYE_PIXELS];
  bit                seeded;
  int unsigned       pix_idx;
  longint unsigned   sq_sum;
  logic [SM_W-1:0]   smooth_dist;
  int unsigned       cur_phase;
  int unsigned       phase_frames;
  logic [15:0]       img_rate, sm_rate;
  logic [11:0]       rise_thr, fall_thr;
  logic [3:0]        rise_min, rise_max, fall_min, fall_max;

  assign pending = blink_q.size();

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Odd phases test for a rise in distance, even phases for a fall.
  function automatic bit ratio_met(int unsigned ph, longint unsigned d8);
    longint unsigned lhs;
    lhs = d8 << 8;
    if (ph[0]) return lhs >= longint'(rise_thr) * smooth_dist;
    return lhs <= longint'(fall_thr) * smooth_dist;
  endfunction

  task automatic take_pixel(input logic [7:0] pix, input logic last);
    longint unsigned p8, a, diff, d8, sm;
    int unsigned dur, ph, mn, mx;
    blink_word_t w;
    p8 = longint'(pix) << 8;
    if (!seeded) begin
      avg_img[pix_idx] = p8[15:0];
    end else begin
      a = avg_img[pix_idx];
      diff = (p8 >= a) ? p8 - a : a - p8;
      sq_sum += diff * diff;
      avg_img[pix_idx] = 16'(((65536 - longint'(img_rate)) * a + longint'(img_rate) * p8
                              + 32768) >> 16);
    end
    if (!last) begin
      pix_idx = (pix_idx + 1) % EYE_PIXELS;
      return;
    end
    d8 = int_root(sq_sum);
    sm = ((65536 - longint'(sm_rate)) * smooth_dist + longint'(sm_rate) * d8 + 32768) >> 16;
    if (sm < 1) sm = 1;
    if (sm > 64'hFFFF_FFFF) sm = 64'hFFFF_FFFF;
    smooth_dist = sm[31:0];
    // The duration check uses the count including this frame, so it may reach 16.
    dur = phase_frames + 1;
    ph = cur_phase;
    if (ph > 0) begin
      mn = ph[0] ? rise_min : fall_min;
      mx = ph[0] ? rise_max : fall_max;
      if ((dur < mn && !ratio_met(ph, d8)) || dur > mx) begin
        ph = 0;
        dur = 0;
      end
    end
    if (ph + 1 < PHASE_COUNT && ratio_met(ph + 1, d8)) begin
      ph = ph + 1;
      dur = 0;
    end
    cur_phase = ph;
    phase_frames = (dur > 15) ? 15 : dur;
    seeded = 1;
    pix_idx = 0;
    sq_sum = 0;
    w.phase = ph[2:0];
    w.distance = ((d8 >> 8) > 65535) ? 16'hFFFF : d8[23:8];
    blink_q = {blink_q, w};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      img_rate = 16'd3277;
      sm_rate = 16'd6554;
      rise_thr = 12'd461;
      fall_thr = 12'd358;
      rise_min = 4'd1;
      rise_max = 4'd8;
      fall_min = 4'd3;
      fall_max = 4'd6;
      seeded = 0;
      pix_idx = 0;
      sq_sum = 0;
      smooth_dist = SM_RESET;
      cur_phase = 0;
      phase_frames = 0;
      fail_count = 0;
      blink_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_RATE:  img_rate = cfg_data;
          REG_SMOOTH_RATE: sm_rate = cfg_data;
          REG_RISE_THR:    rise_thr = cfg_data[11:0];
          REG_FALL_THR:    fall_thr = cfg_data[11:0];
          REG_RISE_MIN:    rise_min = cfg_data[3:0];
          REG_RISE_MAX:    rise_max = cfg_data[3:0];
          REG_FALL_MIN:    fall_min = cfg_data[3:0];
          REG_FALL_MAX:    fall_max = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_pixel(in_pixel, in_last);
      if (out_valid && out_ready) begin
        if (blink_q.size() == 0) begin
          $display("%0t: unexpected result word phase=%0d distance=%0d",
                   $time, out_phase, out_distance);
          fail_count++;
        end else begin
          blink_word_t w;
          w = blink_q.pop_front();
          if (w.phase !== out_phase || w.distance !== out_distance) begin
            $display("%0t: mismatch expected phase=%0d distance=%0d, got phase=%0d distance=%0d",
                     $time, w.phase, w.distance, out_phase, out_distance);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### bench/tb_eye_blink_sequence_detector.sv
// Testbench top of the eye blink sequence detector: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_eye_blink_sequence_detector;
  import ebsd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          send_idle;   // percent of cycles in which the sender holds back
  int          recv_idle;   // percent of cycles in which the receiver stalls
  int          hold_left;   // cycles of a long receiver hold-off still to go
  int          quiet_cycles;

  ebsd_in_if  in_w ();
  ebsd_out_if out_w ();

  eye_blink_sequence_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_w),
    .out_word  (out_w),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ebsd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_w.valid),
    .in_ready     (in_w.ready),
    .in_pixel     (in_w.pixel),
    .in_last      (in_w.last_pixel),
    .out_valid    (out_w.valid),
    .out_ready    (out_w.ready),
    .out_phase    (out_w.phase),
    .out_distance (out_w.distance),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The receiver decides its ready at each falling edge. A long hold-off,
  // when requested, overrides the random stalls until it has counted down.
  initial begin
    out_w.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_w.ready <= 0;
        hold_left = hold_left - 1;
      end else begin
        out_w.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog: the run is stuck if no word moves on either channel for too long.
  // The limit covers the long hold-off plus the slowest frame end.
  always @(posedge clk) begin
    if (!rst_n || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("FAIL eye_blink_sequence_detector");
        $finish;
      end
    end
  end

  // Offers one pixel word and returns at the falling edge after it was taken.
  // Valid is only lowered when the sender idles, so a back-to-back word keeps it high.
  task automatic send_pixel(input logic [7:0] pix, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_w.valid <= 0;
      @(negedge clk);
    end
    in_w.valid <= 1;
    in_w.pixel <= pix;
    in_w.last_pixel <= last;
    do @(posedge clk); while (!in_w.ready);
    @(negedge clk);
  endtask

  // A frame whose pixels sit around a level; spread sets how far they scatter.
  task automatic send_frame(input int len, input int level, input int spread);
    int p;
    for (int i = 0; i < len; i++) begin
      p = level + $urandom_range(2 * spread) - spread;
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      send_pixel(p[7:0], i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Registers change only once the block is idle: every result is in and
  // the frame-end pipeline has had time to drain.
  task automatic drain();
    in_w.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] ir, input logic [15:0] sr,
                            input logic [11:0] rt, input logic [11:0] ft,
                            input logic [3:0] rmin, input logic [3:0] rmax,
                            input logic [3:0] fmin, input logic [3:0] fmax);
    write_reg(REG_IMAGE_RATE, ir);
    write_reg(REG_SMOOTH_RATE, sr);
    write_reg(REG_RISE_THR, {4'd0, rt});
    write_reg(REG_FALL_THR, {4'd0, ft});
    write_reg(REG_RISE_MIN, {12'd0, rmin});
    write_reg(REG_RISE_MAX, {12'd0, rmax});
    write_reg(REG_FALL_MIN, {12'd0, fmin});
    write_reg(REG_FALL_MAX, {12'd0, fmax});
    cfg_we <= 0;
  endtask

  initial begin
    int level, run_len, frame_len, mode;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = REG_IMAGE_RATE;
    cfg_data = 0;
    in_w.valid = 0;
    in_w.pixel = 0;
    in_w.last_pixel = 0;
    send_idle = 16;
    recv_idle = 81;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed part under the reset settings. The first frame runs past the
    // image size and wraps back to entry zero, so every average entry is
    // written and no later frame can read an entry that was never seeded.
    for (int i = 0; i < EYE_PIXELS + 8; i++) begin
      send_pixel(i[7:0] ^ {8{i[8]}}, i == EYE_PIXELS + 7);
    end
    send_frame(1, 255, 0);
    send_frame(1, 0, 0);
    send_frame(3, 255, 0);
    send_frame(4, 0, 0);
    for (int i = 0; i < 6; i++) send_frame(2, (i % 2) ? 0 : 255, 0);
    drain();

    for (int rnd = 0; rnd < 4; rnd++) begin
      case (rnd)
        0: begin
          send_idle = 16;
          recv_idle = 81;
          set_config(16'd3277, 16'd6554, 12'd461, 12'd358, 4'd1, 4'd8, 4'd3, 4'd6);
        end
        1: begin
          send_idle = 81;
          recv_idle = 16;
          set_config(16'hFFFF, 16'd0, 12'hFFF, 12'd0, 4'd15, 4'd0, 4'd15, 4'd0);
        end
        2: begin
          send_idle = 0;
          recv_idle = 0;
          set_config(16'd0, 16'hFFFF, 12'd0, 12'hFFF, 4'd0, 4'd15, 4'd0, 4'd15);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          set_config(16'($urandom), 16'($urandom_range(16384, 1024)),
                     12'($urandom_range(600, 300)), 12'($urandom_range(400, 100)),
                     4'($urandom_range(4)), 4'($urandom_range(15, 3)),
                     4'($urandom_range(4)), 4'($urandom_range(15, 3)));
          // The receiver holds off for a long time while short frames keep
          // coming, so the block backs up and stalls its pixel input.
          hold_left = 3000;
        end
      endcase
      level = $urandom_range(255);
      for (int f = 0; f < 16; ) begin
        // Runs of quiet frames and runs of strongly changed frames follow in random order,
        // which is what walks the phase machine through blinks; a few frames
        // are pure noise.
        run_len = $urandom_range(6, 1);
        frame_len = $urandom_range(8, 2);
        mode = $urandom_range(9);
        for (int k = 0; k < run_len; k++) begin
          if (mode == 0) send_frame($urandom_range(12, 1), 128, 128);
          else if (mode < 5) send_frame(frame_len, level, 2);
          else send_frame(frame_len, 255 - level, 4);
          f++;
        end
      end
      drain();
    end

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS eye_blink_sequence_detector");
    end else begin
      $display("FAIL eye_blink_sequence_detector");
    end
    $finish;
  end

endmodule
